// ----- rtl/core/jsu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// jsu_pkg - shared types for the JSON string unescape block
// Request/result payloads and the decoded-operation record passed from the
// front end to the back end through the operation queue.
// ============================================================================
package jsu_pkg;

    // Input request: one raw byte of the string body
    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
    } jsu_item_t;

    // Output result: one decoded byte, the end of the string, or an error
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        string_done;
        logic [2:0]  error_code;
        logic [15:0] error_offset;
        logic        last_of_run;
    } jsu_result_t;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_CONTROL      = 3'd2;
    localparam logic [2:0] ERR_BAD_UNICODE  = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;

    // Kind of the final result of an operation
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_BYTE = 2'd1;
    localparam logic [1:0] TAIL_DONE = 2'd2;
    localparam logic [1:0] TAIL_ERR  = 2'd3;

    // Most results one request can produce
    localparam int MAX_RESULTS = 6;

    // Decoded operation: up to two code points to encode, then a tail result
    typedef struct packed {
        logic        a_en;
        logic [20:0] cp_a;
        logic        b_en;
        logic [15:0] cp_b;
        logic [1:0]  tail;
        logic [7:0]  tail_byte;
        logic [2:0]  err_code;
        logic [15:0] err_offset;
    } jsu_op_t;

    // Front end to queue write port
    typedef struct packed {
        logic    wr;
        jsu_op_t op;
    } jsu_push_t;

endpackage
`default_nettype wire

// ----- rtl/core/jsu_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// jsu_front - escape parser front end
// Takes one body byte per accepted request, tracks the escape / \u state,
// and turns each byte with results to emit into one decoded operation.
// ============================================================================
module jsu_front
    import jsu_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      take,
    input  jsu_item_t item,
    output jsu_push_t push_req
);

    localparam int PW = OFFSET_BITS + 1;
    localparam int HEX_DIGITS = 4;
    localparam int HEX_LETTER_BASE = 10;

    // Parser phases
    localparam logic [3:0] PH_BODY      = 4'd0;
    localparam logic [3:0] PH_ESC       = 4'd1;
    localparam logic [3:0] PH_HEX0      = 4'd2;
    localparam logic [3:0] PH_HEX3      = 4'd5;
    localparam logic [3:0] PH_CONFIRM   = 4'd6;
    localparam logic [3:0] PH_HELD      = 4'd7;
    localparam logic [3:0] PH_PAIR_BS   = 4'd8;
    localparam logic [3:0] PH_PAIR_HEX0 = 4'd9;
    localparam logic [3:0] PH_PAIR_HEX3 = 4'd12;
    localparam logic [3:0] PH_BADHEX    = 4'd13;
    localparam logic [3:0] PH_FIN       = 4'd14;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            // letters a..f / A..F have low nibble 1..6
            r = {1'b1, b[3:0] + 4'(HEX_LETTER_BASE - 1)};
        end
        return r;
    endfunction

    // {valid, char} of a single-character escape
    function automatic logic [8:0] esc_char(input logic [7:0] b);
        logic [8:0] r;
        unique case (b) inside
            CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, b};
            CH_LOWER_B:                    r = {1'b1, 8'h08};
            CH_LOWER_F:                    r = {1'b1, 8'h0C};
            CH_LOWER_N:                    r = {1'b1, 8'h0A};
            CH_LOWER_R:                    r = {1'b1, 8'h0D};
            CH_LOWER_T:                    r = {1'b1, 8'h09};
            default:                       r = '0;
        endcase
        return r;
    endfunction

    logic                 strict_reg;
    logic [3:0]           phase_reg, phase_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [15:0]          acc_reg, acc_next;
    logic [9:0]           held_reg, held_next;
    logic [PW-1:0]        uoff_reg, uoff_next;

    logic [4:0]           hd;
    logic [8:0]           ec;
    logic                 in_pair;
    logic [1:0]           hex_k;
    logic [15:0]          hex_acc;
    logic                 hex_hi, hex_lo;
    logic [15:0]          held_cp;
    logic [20:0]          cp_pair;
    logic [15:0]          acc_dec;
    logic [1:0]           body_tail, esc_tail;
    logic [3:0]           body_ph, esc_ph;
    logic [PW-1:0]        err_raw;
    logic [OFFSET_BITS-1:0] err_sat;
    logic [OFFSET_BITS+15:0] err_wide;
    jsu_op_t              op;

    // Byte classification
    assign hd      = hex_digit(item.in_byte);
    assign ec      = esc_char(item.in_byte);
    assign in_pair = (phase_reg >= PH_PAIR_HEX0);
    assign hex_k   = in_pair ? 2'(phase_reg - PH_PAIR_HEX0) : 2'(phase_reg - PH_HEX0);
    assign hex_acc = {acc_reg[11:0], hd[3:0]};
    assign hex_hi  = (hex_acc[15:10] == SURR_HIGH);
    assign hex_lo  = (hex_acc[15:10] == SURR_LOW);
    assign held_cp = {SURR_HIGH, held_reg};
    assign cp_pair = 21'h10000 + {1'b0, held_reg, hex_acc[9:0]};
    assign acc_dec = acc_reg - {15'd0, (acc_reg != 16'd0)};

    // Outcome of a byte seen in the plain body
    always_comb
    begin
        body_tail = TAIL_BYTE;
        body_ph   = PH_BODY;
        if (item.in_byte == CH_QUOTE)
        begin
            body_tail = TAIL_DONE;
            body_ph   = PH_FIN;
        end
        else if (item.in_byte == CH_BSLASH)
        begin
            body_tail = TAIL_NONE;
            body_ph   = PH_ESC;
        end
        else if (item.in_byte < CTRL_LIMIT && strict_reg)
        begin
            body_tail = TAIL_ERR;
            body_ph   = PH_FIN;
        end
    end

    // Outcome of a byte following a backslash
    always_comb
    begin
        esc_tail = TAIL_BYTE;
        esc_ph   = PH_BODY;
        if (item.in_byte == CH_LOWER_U)
        begin
            esc_tail = TAIL_NONE;
            esc_ph   = PH_HEX0;
        end
        else if (!ec[8])
        begin
            esc_tail = TAIL_ERR;
            esc_ph   = PH_FIN;
        end
    end

    // Next state and decoded operation
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        uoff_next  = uoff_reg;
        op         = '0;
        err_raw    = '0;

        if (item.at_end)
        begin
            unique case (phase_reg) inside
                PH_BODY, PH_ESC, PH_PAIR_BS:
                begin
                    op.tail     = TAIL_ERR;
                    op.err_code = ERR_UNTERMINATED;
                    phase_next  = PH_FIN;
                end
                [PH_HEX0:PH_HELD], [PH_PAIR_HEX0:PH_BADHEX]:
                begin
                    op.tail     = TAIL_ERR;
                    op.err_code = ERR_BAD_UNICODE;
                    err_raw     = uoff_reg;
                    phase_next  = PH_FIN;
                end
                default: ;
            endcase
        end
        else
        begin
            if (!pos_reg[OFFSET_BITS])
            begin
                pos_next = pos_reg + PW'(1);
            end
            op.tail_byte = item.in_byte;
            unique case (phase_reg) inside
                PH_BODY, PH_CONFIRM:
                begin
                    op.tail     = body_tail;
                    op.err_code = ERR_CONTROL;
                    err_raw     = pos_reg;
                    phase_next  = body_ph;
                end
                PH_ESC:
                begin
                    op.tail      = esc_tail;
                    op.tail_byte = ec[7:0];
                    op.err_code  = ERR_BAD_ESCAPE;
                    err_raw      = pos_reg - PW'(1);
                    phase_next   = esc_ph;
                    if (item.in_byte == CH_LOWER_U)
                    begin
                        uoff_next = pos_reg;
                        acc_next  = '0;
                    end
                end
                [PH_HEX0:PH_HEX3], [PH_PAIR_HEX0:PH_PAIR_HEX3]:
                begin
                    if (!hd[4])
                    begin
                        // count down to the fifth byte after the u
                        acc_next   = 16'(HEX_DIGITS) - {14'd0, hex_k};
                        phase_next = PH_BADHEX;
                    end
                    else
                    begin
                        acc_next = hex_acc;
                        if (hex_k != 2'(HEX_DIGITS - 1))
                        begin
                            phase_next = phase_reg + 4'd1;
                        end
                        else if (in_pair && hex_lo)
                        begin
                            op.a_en    = 1'b1;
                            op.cp_a    = cp_pair;
                            phase_next = PH_CONFIRM;
                        end
                        else
                        begin
                            // unpaired high surrogate goes out first
                            if (in_pair)
                            begin
                                op.a_en = 1'b1;
                                op.cp_a = 21'(held_cp);
                            end
                            if (hex_hi)
                            begin
                                held_next  = hex_acc[9:0];
                                phase_next = PH_HELD;
                            end
                            else if (in_pair)
                            begin
                                op.b_en    = 1'b1;
                                op.cp_b    = hex_acc;
                                phase_next = PH_CONFIRM;
                            end
                            else
                            begin
                                op.a_en    = 1'b1;
                                op.cp_a    = 21'(hex_acc);
                                phase_next = PH_CONFIRM;
                            end
                        end
                    end
                end
                PH_HELD:
                begin
                    if (item.in_byte == CH_BSLASH)
                    begin
                        phase_next = PH_PAIR_BS;
                    end
                    else
                    begin
                        op.a_en     = 1'b1;
                        op.cp_a     = 21'(held_cp);
                        op.tail     = body_tail;
                        op.err_code = ERR_CONTROL;
                        err_raw     = pos_reg;
                        phase_next  = body_ph;
                    end
                end
                PH_PAIR_BS:
                begin
                    if (item.in_byte == CH_LOWER_U)
                    begin
                        uoff_next  = pos_reg;
                        acc_next   = '0;
                        phase_next = PH_PAIR_HEX0;
                    end
                    else
                    begin
                        op.a_en      = 1'b1;
                        op.cp_a      = 21'(held_cp);
                        op.tail      = esc_tail;
                        op.tail_byte = ec[7:0];
                        op.err_code  = ERR_BAD_ESCAPE;
                        err_raw      = pos_reg - PW'(1);
                        phase_next   = esc_ph;
                    end
                end
                PH_BADHEX:
                begin
                    acc_next = acc_dec;
                    if (acc_dec == 16'd0)
                    begin
                        op.tail     = TAIL_ERR;
                        op.err_code = ERR_BAD_UNICODE;
                        err_raw     = uoff_reg + PW'(1);
                        phase_next  = PH_FIN;
                    end
                end
                default: ;
            endcase
        end

        // Saturate the offset, then fit it to the result field
        err_sat       = err_raw[OFFSET_BITS] ? '1 : err_raw[OFFSET_BITS-1:0];
        err_wide      = {16'd0, err_sat};
        op.err_offset = err_wide[15:0];
    end

    assign push_req.op = op;
    assign push_req.wr = take && (op.a_en || op.b_en || op.tail != TAIL_NONE);

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b1;
            phase_reg  <= PH_BODY;
            pos_reg    <= PW'(1);
            acc_reg    <= '0;
            held_reg   <= '0;
            uoff_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                strict_reg <= cfg_wdata;
            end
            if (take)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                acc_reg   <= acc_next;
                held_reg  <= held_next;
                uoff_reg  <= uoff_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/jsu_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// jsu_queue - operation queue between front end and back end
// Small register queue that lets the parser keep taking bytes while the
// back end is busy expanding a multi-byte operation.
// ============================================================================
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  jsu_push_t push_req,
    output logic      full,
    input  logic      rd,
    output logic      valid,
    output jsu_op_t   head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_op_t         slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            wr;

    assign wr    = push_req.wr;
    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= push_req.op;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/jsu_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// jsu_back - UTF-8 encoder and result sequencer
// Expands one queued operation into its list of results and delivers them
// one per cycle through the output register while it is free or popped.
// ============================================================================
module jsu_back
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  jsu_op_t     q_head,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output jsu_result_t result
);

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    // UTF-8 encoding of one code point
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t e;
        e = '0;
        if (cp < 21'h80)
        begin
            e.len      = 3'd1;
            e.bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h800)
        begin
            e.len      = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            e.len      = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            e.len      = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    utf8_t       enc_a, enc_b;
    logic [2:0]  n_a, n_b;
    logic [3:0]  n_ab, n_all;
    jsu_result_t fill_list [MAX_RESULTS];
    jsu_result_t list_reg [MAX_RESULTS];
    logic [2:0]  pos_reg, pos_next;
    logic        busy_reg, busy_next;
    jsu_result_t out_reg;
    logic        out_valid_reg, out_valid_next;
    jsu_result_t cur;
    logic        out_free, emit, load;

    // Build the result list of the queue head
    always_comb
    begin
        enc_a = utf8_encode(q_head.cp_a);
        enc_b = utf8_encode({5'd0, q_head.cp_b});
        n_a   = q_head.a_en ? enc_a.len : 3'd0;
        n_b   = q_head.b_en ? enc_b.len : 3'd0;
        n_ab  = {1'b0, n_a} + {1'b0, n_b};
        n_all = n_ab + {3'd0, (q_head.tail != TAIL_NONE)};
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            fill_list[i] = '0;
            if (4'(i) < {1'b0, n_a})
            begin
                fill_list[i].out_byte   = enc_a.bytes[2'(i)];
                fill_list[i].byte_valid = 1'b1;
            end
            else if (4'(i) < n_ab)
            begin
                fill_list[i].out_byte   = enc_b.bytes[2'(4'(i) - {1'b0, n_a})];
                fill_list[i].byte_valid = 1'b1;
            end
            else
            begin
                case (q_head.tail)
                    TAIL_BYTE:
                    begin
                        fill_list[i].out_byte   = q_head.tail_byte;
                        fill_list[i].byte_valid = 1'b1;
                    end
                    TAIL_DONE:
                    begin
                        fill_list[i].string_done = 1'b1;
                    end
                    TAIL_ERR:
                    begin
                        fill_list[i].error_code   = q_head.err_code;
                        fill_list[i].error_offset = q_head.err_offset;
                    end
                    default: ;
                endcase
            end
            fill_list[i].last_of_run = (4'(i) + 4'd1 == n_all);
        end
    end

    // Sequencing control
    assign cur      = list_reg[pos_reg];
    assign out_free = !out_valid_reg || pop;
    assign emit     = busy_reg && out_free;
    assign load     = q_valid && (!busy_reg || (emit && cur.last_of_run));
    assign q_rd     = load;

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg + 3'd1;
            if (cur.last_of_run)
            begin
                busy_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result list and output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            list_reg <= fill_list;
        end
        if (emit)
        begin
            out_reg <= cur;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

// ----- rtl/core/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// json_string_unescape_utf8 - streaming JSON string body decoder
// Unescapes a JSON string body byte by byte and emits the value as UTF-8,
// with string end and error reports in the same result stream.
// ============================================================================
//
// Channel   Handshake            Payload          Dir
// item      push / full          jsu_item_t       in
// result    empty / pop          jsu_result_t     out
// config    cfg_we / cfg_wdata   strict mode bit  in
//
// One request is taken per cycle while full is low; full rises when
// QUEUE_DEPTH decoded operations wait for the back end.
// The back end delivers one result per cycle while pop keeps up; a byte that
// expands to n results (up to six) keeps it busy until all n are out, so
// input runs at one byte per cycle wherever bytes produce at most one result
// each. A request passes the queue, the result list and the output register.
// Reset: strict mode on, parser in the string body at offset one, queue and
// output register empty. With pop held low the queue backs up to full.
// ============================================================================
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int OFFSET_BITS = 16,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        push,
    output logic        full,
    input  jsu_item_t   item,
    output logic        empty,
    input  logic        pop,
    output jsu_result_t result
);

    logic      take;
    jsu_push_t push_req;
    logic      q_rd, q_valid;
    jsu_op_t   q_head;
    logic      terminal;

    assign take = push && !full;

    // Parser front end
    jsu_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .item      (item),
        .push_req  (push_req)
    );

    // Operation queue
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (push_req),
        .full     (full),
        .rd       (q_rd),
        .valid    (q_valid),
        .head     (q_head)
    );

    // Encoder and result sequencer
    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // Checks
    assign terminal = result.string_done || (result.error_code != ERR_NONE);

    a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && terminal) |-> result.last_of_run)
        else $error("string end or error not marked last of run");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.byte_valid) |->
            (!result.string_done && result.error_code == ERR_NONE
             && result.error_offset == 16'd0))
        else $error("byte result carries end or error fields");

    a_nothing_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && terminal) |=> empty)
        else $error("result delivered after string end or error");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.error_code <= ERR_BAD_ESCAPE))
        else $error("error code out of range");

endmodule
`default_nettype wire
